FILE: hw/rtl/fcfs_schedule_timeline_top_macros.svh
// ----------------------------------------------------------------------------
// FCFS scheduler assertion macros
// Clocked assertion helpers shared by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef FCFS_SCHEDULE_TIMELINE_TOP_MACROS_SVH
`define FCFS_SCHEDULE_TIMELINE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FCFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FCFS_ASSERT_NEVER(lbl, expr, msg) \
  `FCFS_ASSERT(lbl, !(expr), msg)
`else
`define FCFS_ASSERT(lbl, prop, msg)
`define FCFS_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

FILE: hw/rtl/fcfs_pkg.sv
// ----------------------------------------------------------------------------
// FCFS scheduler package
// Field widths, controller commands and status shared by the scheduler.
// ----------------------------------------------------------------------------
package fcfs_pkg;

  localparam int IN_W      = 16;
  localparam int CFG_W     = 16;
  localparam int TIME_W    = 22;
  localparam int RES_W     = 21;
  localparam int IDX_W     = 4;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 48;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_START,
    CMD_INIT,
    CMD_ORD_RD,
    CMD_TL_BEGIN,
    CMD_CUR_LD,
    CMD_CUR_AR,
    CMD_IN_RD,
    CMD_IN_AR,
    CMD_CMP,
    CMD_OUT_WR,
    CMD_TL_RD,
    CMD_TL_AR,
    CMD_TL_ADD,
    CMD_TL_OUT
  } cmd_e;

  typedef struct packed {
    logic full;
    logic i_last;
    logic j_last;
    logic out_free;
  } status_t;

endpackage

FILE: hw/rtl/fcfs_ctrl.sv
// ----------------------------------------------------------------------------
// FCFS scheduler controller
// Sequences loading, order init, exchange sort and timeline emission.
// ----------------------------------------------------------------------------
`include "fcfs_schedule_timeline_top_macros.svh"

module fcfs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  input  logic             s_tlast_i,
  output logic             s_tready_o,
  input  fcfs_pkg::status_t status_i,
  output fcfs_pkg::cmd_e   cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_INIT      = 4'd1;
  localparam logic [3:0] S_OUTER_RD  = 4'd2;
  localparam logic [3:0] S_OUTER_AR  = 4'd3;
  localparam logic [3:0] S_OUTER_CAP = 4'd4;
  localparam logic [3:0] S_IN_RD     = 4'd5;
  localparam logic [3:0] S_IN_AR     = 4'd6;
  localparam logic [3:0] S_IN_CMP    = 4'd7;
  localparam logic [3:0] S_OUTER_WR  = 4'd8;
  localparam logic [3:0] S_TL_RD     = 4'd9;
  localparam logic [3:0] S_TL_AR     = 4'd10;
  localparam logic [3:0] S_TL_ADD    = 4'd11;
  localparam logic [3:0] S_TL_OUT    = 4'd12;

  logic [3:0] state_q, state_d;

  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = fcfs_pkg::CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          if (status_i.full || s_tlast_i) begin
            cmd_o   = fcfs_pkg::CMD_START;
            state_d = S_INIT;
          end else begin
            cmd_o = fcfs_pkg::CMD_LOAD;
          end
        end
      end
      S_INIT: begin
        cmd_o = fcfs_pkg::CMD_INIT;
        if (status_i.i_last) state_d = S_OUTER_RD;
      end
      S_OUTER_RD: begin
        if (status_i.i_last) begin
          cmd_o   = fcfs_pkg::CMD_TL_BEGIN;
          state_d = S_TL_RD;
        end else begin
          cmd_o   = fcfs_pkg::CMD_ORD_RD;
          state_d = S_OUTER_AR;
        end
      end
      S_OUTER_AR: begin
        cmd_o   = fcfs_pkg::CMD_CUR_LD;
        state_d = S_OUTER_CAP;
      end
      S_OUTER_CAP: begin
        cmd_o   = fcfs_pkg::CMD_CUR_AR;
        state_d = S_IN_RD;
      end
      S_IN_RD: begin
        cmd_o   = fcfs_pkg::CMD_IN_RD;
        state_d = S_IN_AR;
      end
      S_IN_AR: begin
        cmd_o   = fcfs_pkg::CMD_IN_AR;
        state_d = S_IN_CMP;
      end
      S_IN_CMP: begin
        cmd_o   = fcfs_pkg::CMD_CMP;
        state_d = status_i.j_last ? S_OUTER_WR : S_IN_RD;
      end
      S_OUTER_WR: begin
        cmd_o   = fcfs_pkg::CMD_OUT_WR;
        state_d = S_OUTER_RD;
      end
      S_TL_RD: begin
        cmd_o   = fcfs_pkg::CMD_TL_RD;
        state_d = S_TL_AR;
      end
      S_TL_AR: begin
        cmd_o   = fcfs_pkg::CMD_TL_AR;
        state_d = S_TL_ADD;
      end
      S_TL_ADD: begin
        cmd_o   = fcfs_pkg::CMD_TL_ADD;
        state_d = S_TL_OUT;
      end
      S_TL_OUT: begin
        if (status_i.out_free) begin
          cmd_o   = fcfs_pkg::CMD_TL_OUT;
          state_d = status_i.i_last ? S_IDLE : S_TL_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `FCFS_ASSERT(a_start_enters_init,
    (state_q == S_IDLE && s_tvalid_i && (status_i.full || s_tlast_i)) |=> state_q == S_INIT,
    "schedule start did not enter init")
  `FCFS_ASSERT_NEVER(a_state_range, state_q > S_TL_OUT, "controller in unused state code")

endmodule

FILE: hw/rtl/fcfs_dp.sv
// ----------------------------------------------------------------------------
// FCFS scheduler datapath
// Job stores, order store, sort and timeline registers, output register.
// ----------------------------------------------------------------------------
`include "fcfs_schedule_timeline_top_macros.svh"

module fcfs_dp #(
  parameter int MAX_PROCS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fcfs_pkg::cmd_e                    cmd_i,
  output fcfs_pkg::status_t                 status_o,
  input  logic [fcfs_pkg::IN_W-1:0]         arrival_i,
  input  logic [fcfs_pkg::IN_W-1:0]         burst_i,
  input  logic [fcfs_pkg::CFG_W-1:0]        ctx_switch_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [fcfs_pkg::IDX_W-1:0]        job_index_o,
  output logic [fcfs_pkg::RES_W-1:0]        turnaround_o,
  output logic [fcfs_pkg::RES_W-1:0]        waiting_o,
  output logic                              last_result_o
);

  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int TW = fcfs_pkg::TIME_W;
  localparam int NW = fcfs_pkg::IN_W;

  logic [NW-1:0] arr_mem [MAX_PROCS];
  logic [NW-1:0] bur_mem [MAX_PROCS];
  logic [IW-1:0] ord_mem [MAX_PROCS];

  logic [CW-1:0] count_q, i_q, j_q;
  logic [IW-1:0] cur_q, ord_rd_q;
  logic [NW-1:0] cur_arr_q, arr_rd_q, bur_rd_q;
  logic [TW-1:0] ct_q, fin_q, wt_q;
  logic          first_q;
  logic          out_valid_q;

  logic          store_we, ord_we, ord_re, arr_re, bur_re;
  logic [IW-1:0] ord_waddr, ord_wdata, ord_raddr;
  logic          greater;
  logic [TW-1:0] arr_ext, bur_ext, base, tat;
  logic          i_last;

  assign i_last  = ((CW+1)'(i_q) + (CW+1)'(1)) >= (CW+1)'(count_q);
  assign greater = cur_arr_q > arr_rd_q;
  assign arr_ext = TW'(arr_rd_q);
  assign bur_ext = TW'(bur_rd_q);
  assign base    = (first_q || (arr_ext > ct_q)) ? arr_ext : ct_q;
  assign tat     = fin_q - arr_ext;

  assign status_o.full     = (count_q == CW'(MAX_PROCS));
  assign status_o.i_last   = i_last;
  assign status_o.j_last   = ((CW+1)'(j_q) + (CW+1)'(1)) >= (CW+1)'(count_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    store_we  = 1'b0;
    ord_we    = 1'b0;
    ord_re    = 1'b0;
    arr_re    = 1'b0;
    bur_re    = 1'b0;
    ord_waddr = i_q[IW-1:0];
    ord_wdata = cur_q;
    ord_raddr = i_q[IW-1:0];
    unique case (cmd_i)
      fcfs_pkg::CMD_LOAD:  store_we = 1'b1;
      fcfs_pkg::CMD_START: store_we = !status_o.full;
      fcfs_pkg::CMD_INIT: begin
        ord_we    = 1'b1;
        ord_wdata = i_q[IW-1:0];
      end
      fcfs_pkg::CMD_ORD_RD: ord_re = 1'b1;
      fcfs_pkg::CMD_CUR_LD: arr_re = 1'b1;
      fcfs_pkg::CMD_IN_RD: begin
        ord_re    = 1'b1;
        ord_raddr = j_q[IW-1:0];
      end
      fcfs_pkg::CMD_IN_AR: arr_re = 1'b1;
      fcfs_pkg::CMD_CMP: begin
        ord_we    = greater;
        ord_waddr = j_q[IW-1:0];
      end
      fcfs_pkg::CMD_OUT_WR: ord_we = 1'b1;
      fcfs_pkg::CMD_TL_RD:  ord_re = 1'b1;
      fcfs_pkg::CMD_TL_AR: begin
        arr_re = 1'b1;
        bur_re = 1'b1;
      end
      fcfs_pkg::CMD_NONE, fcfs_pkg::CMD_TL_BEGIN, fcfs_pkg::CMD_CUR_AR,
      fcfs_pkg::CMD_TL_ADD, fcfs_pkg::CMD_TL_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      arr_mem[count_q[IW-1:0]] <= arrival_i;
      bur_mem[count_q[IW-1:0]] <= burst_i;
    end
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    if (ord_re) ord_rd_q <= ord_mem[ord_raddr];
    if (arr_re) arr_rd_q <= arr_mem[ord_rd_q];
    if (bur_re) bur_rd_q <= bur_mem[ord_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == fcfs_pkg::CMD_CUR_LD) cur_q <= ord_rd_q;
    if (cmd_i == fcfs_pkg::CMD_CUR_AR) cur_arr_q <= arr_rd_q;
    if (cmd_i == fcfs_pkg::CMD_CMP && greater) begin
      cur_q     <= ord_rd_q;
      cur_arr_q <= arr_rd_q;
    end
    if (cmd_i == fcfs_pkg::CMD_TL_ADD) begin
      fin_q <= base + bur_ext;
      wt_q  <= base - arr_ext;
    end
    if (cmd_i == fcfs_pkg::CMD_TL_OUT) begin
      job_index_o   <= fcfs_pkg::IDX_W'(ord_rd_q);
      turnaround_o  <= tat[fcfs_pkg::RES_W-1:0];
      waiting_o     <= wt_q[fcfs_pkg::RES_W-1:0];
      last_result_o <= i_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      ct_q        <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i == fcfs_pkg::CMD_TL_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i)
        fcfs_pkg::CMD_LOAD: count_q <= count_q + CW'(1);
        fcfs_pkg::CMD_START: begin
          if (!status_o.full) count_q <= count_q + CW'(1);
          i_q <= '0;
        end
        fcfs_pkg::CMD_INIT:   i_q <= i_last ? '0 : i_q + CW'(1);
        fcfs_pkg::CMD_CUR_LD: j_q <= i_q + CW'(1);
        fcfs_pkg::CMD_CMP:    j_q <= j_q + CW'(1);
        fcfs_pkg::CMD_OUT_WR: i_q <= i_q + CW'(1);
        fcfs_pkg::CMD_TL_BEGIN: begin
          i_q     <= '0;
          first_q <= 1'b1;
        end
        fcfs_pkg::CMD_TL_OUT: begin
          ct_q    <= fin_q + TW'(ctx_switch_i);
          first_q <= 1'b0;
          i_q     <= i_q + CW'(1);
          if (i_last) count_q <= '0;
        end
        fcfs_pkg::CMD_NONE, fcfs_pkg::CMD_ORD_RD, fcfs_pkg::CMD_CUR_AR,
        fcfs_pkg::CMD_IN_RD, fcfs_pkg::CMD_IN_AR, fcfs_pkg::CMD_TL_RD,
        fcfs_pkg::CMD_TL_AR, fcfs_pkg::CMD_TL_ADD: ;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  `FCFS_ASSERT_NEVER(a_count_bound, count_q > CW'(MAX_PROCS), "job count above store depth")
  `FCFS_ASSERT(a_no_overwrite, cmd_i == fcfs_pkg::CMD_TL_OUT |-> (!out_valid_q || out_ready_i),
    "result register overwritten while held")
  `FCFS_ASSERT(a_count_cleared, (cmd_i == fcfs_pkg::CMD_TL_OUT && i_last) |=> count_q == '0,
    "job count not cleared after final result")
  `FCFS_ASSERT(a_load_not_full, cmd_i == fcfs_pkg::CMD_LOAD |-> !status_o.full,
    "job stored while store full")

endmodule

FILE: hw/rtl/fcfs_schedule_timeline_top.sv
// ----------------------------------------------------------------------------
// FCFS schedule timeline top
// Loads jobs, sorts by arrival and emits turnaround/waiting per job.
// Jobs load at one per cycle; the last job, or a job offered to a full store
// (that job is dropped), starts the schedule, during which no job is taken.
// The schedule runs order init, an exchange sort (single-port order store),
// then emits results as the output takes them, from a registered stage.
// Reset (async, active low) clears control, job count, timeline and register.
// ----------------------------------------------------------------------------
module fcfs_schedule_timeline_top #(
  parameter int MAX_PROCS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: arrival_time[15:0], burst_time[31:16]
  input  logic [fcfs_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  input  logic                              s_axis_tvalid_i,
  input  logic                              s_axis_tlast_i,
  output logic                              s_axis_tready_o,
  // tdata: job_index[3:0], turnaround[24:4], waiting[45:25], zero pad[47:46]
  output logic [fcfs_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                              m_axis_tvalid_o,
  output logic                              m_axis_tlast_o,
  input  logic                              m_axis_tready_i,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fcfs_pkg::APB_AW-1:0]       paddr,
  input  logic [fcfs_pkg::APB_DW-1:0]       pwdata,
  output logic [fcfs_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  localparam int PAD_W = fcfs_pkg::M_TDATA_W - fcfs_pkg::IDX_W - 2 * fcfs_pkg::RES_W;

  fcfs_pkg::cmd_e    cmd;
  fcfs_pkg::status_t status;

  logic [fcfs_pkg::CFG_W-1:0] ctx_switch_q;
  logic [fcfs_pkg::IDX_W-1:0] job_index;
  logic [fcfs_pkg::RES_W-1:0] turnaround, waiting;
  logic                       reg0_sel;

  assign pready   = 1'b1;
  assign reg0_sel = !paddr[2];
  assign prdata   = reg0_sel ? fcfs_pkg::APB_DW'(ctx_switch_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_switch_q <= '0;
    end else if (psel && penable && pwrite && pready && reg0_sel) begin
      ctx_switch_q <= pwdata[fcfs_pkg::CFG_W-1:0];
    end
  end

  fcfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tlast_i  (s_axis_tlast_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fcfs_dp #(
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .arrival_i     (s_axis_tdata_i[fcfs_pkg::IN_W-1:0]),
    .burst_i       (s_axis_tdata_i[2*fcfs_pkg::IN_W-1:fcfs_pkg::IN_W]),
    .ctx_switch_i  (ctx_switch_q),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .job_index_o   (job_index),
    .turnaround_o  (turnaround),
    .waiting_o     (waiting),
    .last_result_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{PAD_W{1'b0}}, waiting, turnaround, job_index};

endmodule

FILE: test/fcfs_sched_checker.sv
// ----------------------------------------------------------------------------
// FCFS schedule checker
// Watches the job stream, the result stream and the register port. Each job
// transfer is loaded into a private copy of the job store; the transfer that
// closes a batch runs an exchange sort on arrival ticks and the timeline, and
// queues the expected results. Every result transfer is compared field by
// field with the oldest queued result. Register read data is checked as well.
// ----------------------------------------------------------------------------
module fcfs_sched_checker
  import fcfs_pkg::*;
#(
  parameter logic [APB_AW-1:0] CSW_ADDR = '0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tdata: arrival_time[15:0], burst_time[31:16]
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic                 s_tvalid_i,
  input  logic                 s_tlast_i,
  input  logic                 s_tready_i,
  // tdata: job_index[3:0], turnaround[24:4], waiting[45:25], zero pad[47:46]
  input  logic [M_TDATA_W-1:0] m_tdata_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tlast_i,
  input  logic                 m_tready_i,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [APB_AW-1:0]    paddr_i,
  input  logic [APB_DW-1:0]    pwdata_i,
  input  logic [APB_DW-1:0]    prdata_i,
  input  logic                 pready_i,
  output int                   pending_o,
  output int                   errors_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_JOBS = 16;

  typedef struct packed {
    logic [IDX_W-1:0] job_index;
    logic [RES_W-1:0] turnaround;
    logic [RES_W-1:0] waiting;
    logic             last_result;
  } job_result_t;

  logic [IN_W-1:0]  arrival_mem [MAX_JOBS];
  logic [IN_W-1:0]  burst_mem   [MAX_JOBS];
  int               job_cnt;
  logic [CFG_W-1:0] csw_ticks;
  job_result_t      sched_q [$];
  int               errs;

  task automatic run_fcfs();
    int               n;
    logic [IDX_W-1:0] ord [MAX_JOBS];
    logic [IDX_W-1:0] tmp;
    logic [IDX_W-1:0] k;
    logic [TIME_W-1:0] timeline;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    job_result_t      res;
    n = job_cnt;
    for (int i = 0; i < n; i++) ord[i] = IDX_W'(i);
    for (int i = 0; i + 1 < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (arrival_mem[ord[i]] > arrival_mem[ord[j]]) begin
          tmp    = ord[i];
          ord[i] = ord[j];
          ord[j] = tmp;
        end
      end
    end
    timeline = TIME_W'(arrival_mem[ord[0]]);
    for (int i = 0; i < n; i++) begin
      k = ord[i];
      if (TIME_W'(arrival_mem[k]) > timeline) timeline = TIME_W'(arrival_mem[k]);
      timeline = timeline + TIME_W'(burst_mem[k]);
      tat = timeline - TIME_W'(arrival_mem[k]);
      wt  = tat - TIME_W'(burst_mem[k]);
      res.job_index   = k;
      res.turnaround  = tat[RES_W-1:0];
      res.waiting     = wt[RES_W-1:0];
      res.last_result = (i == n - 1);
      sched_q.push_back(res);
      timeline = timeline + TIME_W'(csw_ticks);
    end
    job_cnt = 0;
  endtask

  task automatic take_job(input logic [S_TDATA_W-1:0] data, input logic last);
    if (job_cnt >= MAX_JOBS) begin
      // store full: this job is dropped and the batch is scheduled
      run_fcfs();
    end else begin
      arrival_mem[job_cnt] = data[IN_W-1:0];
      burst_mem[job_cnt]   = data[2*IN_W-1:IN_W];
      job_cnt++;
      if (last) run_fcfs();
    end
  endtask

  task automatic check_result(input logic [M_TDATA_W-1:0] data, input logic last);
    job_result_t want;
    if (sched_q.size() == 0) begin
      $error("result transfer with no expected result: tdata=%h", data);
      errs++;
    end else begin
      want = sched_q.pop_front();
      if (data[IDX_W-1:0] !== want.job_index) begin
        $error("job_index: expected %0d, got %0d", want.job_index, data[IDX_W-1:0]);
        errs++;
      end
      if (data[IDX_W+RES_W-1:IDX_W] !== want.turnaround) begin
        $error("turnaround: expected %0d, got %0d", want.turnaround,
               data[IDX_W+RES_W-1:IDX_W]);
        errs++;
      end
      if (data[IDX_W+2*RES_W-1:IDX_W+RES_W] !== want.waiting) begin
        $error("waiting: expected %0d, got %0d", want.waiting,
               data[IDX_W+2*RES_W-1:IDX_W+RES_W]);
        errs++;
      end
      if (last !== want.last_result) begin
        $error("last_result: expected %0d, got %0d", want.last_result, last);
        errs++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_cnt   = 0;
      csw_ticks = '0;
      sched_q.delete();
      errs      = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i == CSW_ADDR) csw_ticks = pwdata_i[CFG_W-1:0];
        end else if (paddr_i == CSW_ADDR &&
                     prdata_i !== {{(APB_DW-CFG_W){1'b0}}, csw_ticks}) begin
          $error("context_switch_time: expected %0d, got %0d", csw_ticks, prdata_i);
          errs++;
        end
      end
      if (s_tvalid_i && s_tready_i) take_job(s_tdata_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) check_result(m_tdata_i, m_tlast_i);
      pending_o <= sched_q.size();
      errors_o  <= errs;
    end
  end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// FCFS schedule timeline testbench
// Drives job batches into the scheduler and throttles its result stream.
// A directed part covers single jobs, arrival ties, field extremes, the
// context-switch extremes, a write to an unused register and a batch that
// overruns the job store; random batches of mixed sizes follow, across
// several context-switch settings, with a long result hold-off and a
// drained pause. Prediction and checking sit in the checker module.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import fcfs_pkg::*;

  localparam int                MAX_PROCS   = 16;
  localparam logic [APB_AW-1:0] CSW_ADDR    = 3'd0;
  localparam logic [APB_AW-1:0] UNUSED_ADDR = 3'd4;
  localparam int                RAND_ITEMS  = 160;
  localparam int                QUIET_AT    = 135;
  localparam int                LONG_HOLD   = 300;
  localparam int                SETTLE      = 8;
  localparam int                TAIL        = 20;
  localparam int                WATCHDOG    = 5000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic [S_TDATA_W-1:0] s_data;
  logic                 s_valid;
  logic                 s_last;
  logic                 s_ready;
  logic [M_TDATA_W-1:0] m_data;
  logic                 m_valid;
  logic                 m_last;
  logic                 m_ready;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;
  int                   pending;
  int                   errors;
  logic                 quiet;
  logic                 hold_req;
  int                   items_sent;
  int                   tx_calm;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fcfs_schedule_timeline_top #(.MAX_PROCS(MAX_PROCS)) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tlast_i  (s_last),
    .s_axis_tready_o (s_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tlast_o  (m_last),
    .m_axis_tready_i (m_ready),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  fcfs_sched_checker #(.CSW_ADDR(CSW_ADDR)) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tdata_i  (s_data),
    .s_tvalid_i (s_valid),
    .s_tlast_i  (s_last),
    .s_tready_i (s_ready),
    .m_tdata_i  (m_data),
    .m_tvalid_i (m_valid),
    .m_tlast_i  (m_last),
    .m_tready_i (m_ready),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_i   (prdata),
    .pready_i   (pready),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  function automatic logic [IN_W-1:0] pick_val(input int mode);
    case (mode)
      0: return IN_W'($urandom_range(0, 65535));
      1: return IN_W'($urandom_range(0, 40));
      default: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return '1;
          default: return IN_W'($urandom_range(0, 65535));
        endcase
      end
    endcase
  endfunction

  task automatic send_job(input logic [IN_W-1:0] arr, input logic [IN_W-1:0] bur,
                          input logic last);
    int gap;
    if (!quiet) begin
      if (tx_calm > 0) begin
        tx_calm--;
      end else if ($urandom_range(0, 9) == 0) begin
        tx_calm = $urandom_range(10, 40);
      end else if ($urandom_range(0, 2) == 0) begin
        gap = $urandom_range(1, 19);
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_data  <= {bur, arr};
    s_last  <= last;
    s_valid <= 1'b1;
    do @(posedge clk); while (!s_ready);
    items_sent++;
  endtask

  task automatic send_batch(input int n, input logic overrun);
    int ma;
    int mb;
    ma = $urandom_range(0, 2);
    mb = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) send_job(pick_val(ma), pick_val(mb), (i == n - 1) && !overrun);
    if (overrun) send_job(pick_val(0), pick_val(0), 1'($urandom_range(0, 1)));
  endtask

  // stop offering jobs and wait until every scheduled result has been taken
  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_csw(input logic [CFG_W-1:0] ticks);
    apb_access(1'b1, CSW_ADDR, APB_DW'(ticks));
    apb_access(1'b0, CSW_ADDR, '0);
  endtask

  // result side: random stall bursts, calm stretches, one long hold-off
  initial begin : result_sink
    int  gap;
    int  calm;
    int  hold;
    logic hold_done;
    gap       = 0;
    calm      = 0;
    hold      = 0;
    hold_done = 1'b0;
    m_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold      = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        m_ready <= 1'b0;
      end else if (gap > 0 && !quiet) begin
        gap--;
        m_ready <= 1'b0;
      end else if (quiet) begin
        m_ready <= 1'b1;
      end else if (calm > 0) begin
        calm--;
        m_ready <= 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
        calm = $urandom_range(20, 60);
        m_ready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        gap = $urandom_range(0, 18);
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG) begin
      @(posedge clk);
      if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
        idle = 0;
      else
        idle++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int                base;
    int                phase;
    int                sel;
    logic [CFG_W-1:0] phase_csw [2];
    rst_n      = 1'b0;
    s_valid   <= 1'b0;
    s_data    <= '0;
    s_last    <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    quiet     <= 1'b0;
    hold_req  <= 1'b0;
    items_sent = 0;
    tx_calm    = 0;
    phase      = 0;
    phase_csw[0] = '0;
    phase_csw[1] = 16'd1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of the register, then lone job and arrival ties
    apb_access(1'b0, CSW_ADDR, '0);
    send_job(16'd0, 16'd0, 1'b1);
    send_job(16'hFFFF, 16'hFFFF, 1'b0);
    send_job(16'h0000, 16'h0000, 1'b0);
    send_job(16'hFFFF, 16'h0001, 1'b1);
    drain();

    // widest context switch; unused register must not change it
    set_csw(16'hFFFF);
    apb_access(1'b1, UNUSED_ADDR, 32'h0000_1234);
    apb_access(1'b0, CSW_ADDR, '0);

    // fill the store without a last flag; the extra job is dropped
    for (int i = 0; i < MAX_PROCS; i++)
      send_job(IN_W'((15 - i) / 2 * 4000), 16'hFFFF, 1'b0);
    send_job(16'hAAAA, 16'h5555, 1'b1);
    drain();
    set_csw(IN_W'($urandom_range(0, 65535)));

    base = items_sent;
    while (items_sent - base < RAND_ITEMS) begin
      if (phase < 2 && items_sent - base >= 60 * (phase + 1)) begin
        drain();
        set_csw(phase_csw[phase]);
        phase++;
        // first new phase: hold off the result side while batches keep coming
        if (phase == 1) hold_req <= 1'b1;
      end
      if (items_sent - base >= QUIET_AT) quiet <= 1'b1;
      sel = $urandom_range(0, 9);
      if (sel == 0)
        send_batch(MAX_PROCS, 1'b1);
      else if (sel == 1)
        send_batch(MAX_PROCS, 1'b0);
      else
        send_batch($urandom_range(1, 6), 1'b0);
    end

    s_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL) @(posedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: fcfs_schedule_timeline_top.f
+incdir+hw/rtl
hw/rtl/fcfs_pkg.sv
hw/rtl/fcfs_ctrl.sv
hw/rtl/fcfs_dp.sv
hw/rtl/fcfs_schedule_timeline_top.sv
test/fcfs_sched_checker.sv
test/tb.sv
